@@ rtl/core/rsd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_pkg
// shared constants, codes and control types of the record stream deframer
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int          PEEK_DEPTH   = 10;
   localparam int          PEEK_IDX_W   = 4;
   localparam logic [31:0] PEEK_WORDS   = 32'd10;
   localparam logic [31:0] HDR_WORDS    = 32'd8;
   localparam logic [31:0] REC_MAGIC    = 32'hc0da0100;
   localparam logic [31:0] REC_MAGIC_SWAPPED = 32'h0001dac0;
   localparam logic [31:0] WORDS_PER_MB = 32'(1024 * 1024 / 4);
   localparam logic [31:0] MAX_WORDS_RESET = 32'(64 * 1024 * 1024 / 4);

   // framing codes
   localparam logic [1:0] MODE_AUTO     = 2'd0;
   localparam logic [1:0] MODE_PREFIXED = 2'd1;
   localparam logic [1:0] MODE_HEADER   = 2'd2;
   localparam logic [1:0] MODE_RAW      = 2'd3;

   // register indexes
   localparam logic CSR_FRAMING_MODE = 1'b0;
   localparam logic CSR_MAX_WORDS    = 1'b1;

   // input item kinds
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   typedef enum logic [2:0] {
      STAT_PAYLOAD   = 3'd0,
      STAT_CLOSE     = 3'd1,
      STAT_MIDRECORD = 3'd2,
      STAT_UNDETECT  = 3'd3,
      STAT_SWAPPED   = 3'd4,
      STAT_MAGIC     = 3'd5,
      STAT_LENGTH    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      START_NONE = 2'd0,
      START_HDR  = 2'd1,
      START_PEEK = 2'd2,
      START_RAW  = 2'd3
   } start_src_type;

   typedef struct packed {
      logic                  peek_wr;
      logic                  banner_shift;
      logic                  hidx_inc;
      logic                  hidx_clr;
      logic                  hlen_ld;
      start_src_type         start_src;
      logic                  mode_ld;
      logic                  emit;
      logic                  emit_peek;
      logic                  drain_ld;
      logic [PEEK_IDX_W-1:0] drain_start;
      logic                  drain_inc;
      logic                  put;
      status_type            put_status;
      logic                  end_run;
      logic                  close;
   } cmd_type;

   typedef struct packed {
      logic                  out_free;
      logic [PEEK_IDX_W-1:0] peek_cnt;
      logic                  banner;
      logic [2:0]            hidx;
      logic [1:0]            mode;
      logic                  fin_banner;
      logic [1:0]            fin_mode;
      logic                  fin_swapped;
      logic                  fin_hdr_ok;
      logic                  fin_len_ok;
      logic                  word_magic;
      logic                  hlen_ok;
      logic                  raw_ok;
      logic                  last_word;
      logic [PEEK_IDX_W-1:0] drain_idx;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/core/rsd_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_req_if
// input channel: data words and connection-end items
// ----------------------------------------------------------------------------
interface rsd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] data_word;

   modport source (output valid, output req_type, output data_word, input ready);
   modport sink (input valid, input req_type, input data_word, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rsd_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_rsp_if
// result channel: payload words and connection status
// ----------------------------------------------------------------------------
interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] payload_word;
   logic [2:0]  status;
   logic        end_of_record;
   logic        end_of_run;
   logic        length_mismatch;
   logic        order_fault;
   logic [31:0] frame_tag;
   logic [1:0]  framing_found;
   logic        banner_seen;

   modport source (output valid, output payload_word, output status, output end_of_record,
                   output end_of_run, output length_mismatch, output order_fault,
                   output frame_tag, output framing_found, output banner_seen,
                   input ready);
   modport sink (input valid, input payload_word, input status, input end_of_record,
                 input end_of_run, input length_mismatch, input order_fault,
                 input frame_tag, input framing_found, input banner_seen,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/core/record_stream_deframer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// record_stream_deframer_unit
// length-prefixed record deframer with banner drop and framing detection
// ----------------------------------------------------------------------------
//  channel   direction  handshake        transaction carries
//  req_chan  in         valid / ready    req_type, data_word
//  rsp_chan  out        valid / ready    payload word, status and record flags
//  csr_*     in         csr_we only      framing mode, record length limit
//
//  one data word or connection end per cycle while the result register is free
//  after the tenth word of a connection, req is held off in the decision state
//  the drain then emits up to ten peek-store words, one per cycle while output is free
//  synchronous active-high reset; the peek store needs no clearing pass
//  a stalled result register stalls req as well, nothing is dropped
// ----------------------------------------------------------------------------
module record_stream_deframer_unit
   import rsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   rsd_req_if.sink          req_chan,
   rsd_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // framing state machine
   rsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, checks and result register
   rsd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_word            (req_chan.data_word),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_payload_word    (rsp_chan.payload_word),
      .rsp_status          (rsp_chan.status),
      .rsp_end_of_record   (rsp_chan.end_of_record),
      .rsp_end_of_run      (rsp_chan.end_of_run),
      .rsp_length_mismatch (rsp_chan.length_mismatch),
      .rsp_order_fault     (rsp_chan.order_fault),
      .rsp_frame_tag       (rsp_chan.frame_tag),
      .rsp_framing_found   (rsp_chan.framing_found),
      .rsp_banner_seen     (rsp_chan.banner_seen)
   );

   // a connection-end transaction always leaves an empty peek store
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.req_type == REQ_END
      |=> stat.peek_cnt == '0)
      else $error("peek count not cleared after connection end");

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> stat.out_free)
      else $error("result register overwritten");

   // record end only marks payload words
   a_eor_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_record |-> rsp_chan.status == STAT_PAYLOAD)
      else $error("end of record on a status result");

endmodule
`default_nettype wire

@@ rtl/core/rsd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_ctrl
// framing state machine, issues commands to the datapath
// ----------------------------------------------------------------------------
module rsd_ctrl
   import rsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_type,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [7:0] {
      ST_DETECT  = 8'b0000_0001,
      ST_FINISH  = 8'b0000_0010,
      ST_PREFIX  = 8'b0000_0100,
      ST_HEADER  = 8'b0000_1000,
      ST_PAYLOAD = 8'b0001_0000,
      ST_RAWLEN  = 8'b0010_0000,
      ST_DRAIN   = 8'b0100_0000,
      ST_ERROR   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in, after_record;
   logic      accept, clean, drain_last;

   always_comb begin
      case (stat.mode)
         MODE_RAW:      after_record = ST_RAWLEN;
         MODE_PREFIXED: after_record = ST_PREFIX;
         default:       after_record = ST_HEADER;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_DETECT: clean = (stat.peek_cnt == '0)
                          || (!stat.banner && stat.peek_cnt == PEEK_IDX_W'(1))
                          || (stat.banner && stat.peek_cnt == PEEK_IDX_W'(8));
         ST_PREFIX: clean = (stat.hidx == '0);
         ST_HEADER: clean = (stat.hidx == '0) && (stat.mode == MODE_HEADER);
         ST_RAWLEN: clean = 1'b1;
         default:   clean = 1'b0;
      endcase
   end

   assign drain_last = (stat.drain_idx == PEEK_IDX_W'(PEEK_DEPTH - 1)) || stat.last_word;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = stat.out_free && (state_ff != ST_FINISH) && (state_ff != ST_DRAIN);
      accept    = req_valid && req_ready;

      if (accept && req_type == REQ_END) begin
         cmd.close      = 1'b1;
         cmd.put        = (state_ff != ST_ERROR);
         cmd.put_status = clean ? STAT_CLOSE : STAT_MIDRECORD;
         cmd.end_run    = 1'b1;
         state_in       = ST_DETECT;
      end else begin
         case (state_ff)
            ST_DETECT: begin
               if (accept) begin
                  cmd.peek_wr = 1'b1;
                  if (stat.peek_cnt == PEEK_IDX_W'(PEEK_DEPTH - 1)) state_in = ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (stat.out_free) begin
                  cmd.end_run = 1'b1;
                  if (stat.fin_banner) begin
                     cmd.banner_shift = 1'b1;
                     state_in         = ST_DETECT;
                  end else if (stat.fin_mode == MODE_AUTO) begin
                     cmd.put        = 1'b1;
                     cmd.put_status = STAT_UNDETECT;
                     state_in       = ST_ERROR;
                  end else begin
                     cmd.mode_ld = 1'b1;
                     if (stat.fin_swapped) begin
                        cmd.put        = 1'b1;
                        cmd.put_status = STAT_SWAPPED;
                        state_in       = ST_ERROR;
                     end else if (stat.fin_mode != MODE_RAW && !stat.fin_hdr_ok) begin
                        cmd.put        = 1'b1;
                        cmd.put_status = STAT_MAGIC;
                        state_in       = ST_ERROR;
                     end else if (!stat.fin_len_ok) begin
                        cmd.put        = 1'b1;
                        cmd.put_status = STAT_LENGTH;
                        state_in       = ST_ERROR;
                     end else begin
                        cmd.start_src = START_PEEK;
                        case (stat.fin_mode)
                           MODE_RAW: begin
                              cmd.drain_ld    = 1'b1;
                              cmd.drain_start = '0;
                              state_in        = ST_DRAIN;
                           end
                           MODE_HEADER: begin
                              cmd.drain_ld    = 1'b1;
                              cmd.drain_start = PEEK_IDX_W'(HDR_WORDS);
                              state_in        = ST_DRAIN;
                           end
                           default: state_in = ST_PAYLOAD;
                        endcase
                     end
                  end
               end
            end
            ST_PREFIX: begin
               if (accept) begin
                  if (stat.hidx == 3'd1) begin
                     cmd.hidx_clr = 1'b1;
                     state_in     = ST_HEADER;
                  end else begin
                     cmd.hidx_inc = 1'b1;
                  end
               end
            end
            ST_HEADER: begin
               if (accept) begin
                  cmd.hlen_ld = (stat.hidx == '0);
                  if (stat.hidx == 3'(HDR_WORDS - 32'd1)) begin
                     cmd.hidx_clr = 1'b1;
                     cmd.end_run  = 1'b1;
                     if (!stat.word_magic) begin
                        cmd.put        = 1'b1;
                        cmd.put_status = STAT_MAGIC;
                        state_in       = ST_ERROR;
                     end else if (!stat.hlen_ok) begin
                        cmd.put        = 1'b1;
                        cmd.put_status = STAT_LENGTH;
                        state_in       = ST_ERROR;
                     end else begin
                        cmd.start_src = START_HDR;
                        state_in      = ST_PAYLOAD;
                     end
                  end else begin
                     cmd.hidx_inc = 1'b1;
                  end
               end
            end
            ST_PAYLOAD: begin
               if (accept) begin
                  cmd.emit       = 1'b1;
                  cmd.put        = 1'b1;
                  cmd.put_status = STAT_PAYLOAD;
                  cmd.end_run    = 1'b1;
                  if (stat.last_word) begin
                     cmd.hidx_clr = 1'b1;
                     state_in     = after_record;
                  end
               end
            end
            ST_RAWLEN: begin
               if (accept) begin
                  cmd.put     = 1'b1;
                  cmd.end_run = 1'b1;
                  if (!stat.raw_ok) begin
                     cmd.put_status = STAT_LENGTH;
                     state_in       = ST_ERROR;
                  end else begin
                     cmd.start_src  = START_RAW;
                     cmd.emit       = 1'b1;
                     cmd.put_status = STAT_PAYLOAD;
                     state_in       = ST_PAYLOAD;
                  end
               end
            end
            ST_DRAIN: begin
               if (stat.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_peek  = 1'b1;
                  cmd.put        = 1'b1;
                  cmd.put_status = STAT_PAYLOAD;
                  cmd.end_run    = drain_last;
                  cmd.drain_inc  = 1'b1;
                  if (stat.last_word) begin
                     cmd.hidx_clr = 1'b1;
                     state_in     = after_record;
                  end else if (drain_last) begin
                     state_in = ST_PAYLOAD;
                  end
               end
            end
            ST_ERROR: ;
            default: state_in = ST_DETECT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DETECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rsd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_datapath
// peek store, record counters, checks and the result register
// ----------------------------------------------------------------------------
module rsd_datapath
   import rsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic [31:0] req_word,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [31:0]      rsp_payload_word,
   output logic [2:0]       rsp_status,
   output logic             rsp_end_of_record,
   output logic             rsp_end_of_run,
   output logic             rsp_length_mismatch,
   output logic             rsp_order_fault,
   output logic [31:0]      rsp_frame_tag,
   output logic [1:0]       rsp_framing_found,
   output logic             rsp_banner_seen
);

   logic [1:0]            framing_mode_ff;
   logic [31:0]           max_words_ff;
   logic [31:0]           peek_ff [PEEK_DEPTH];
   logic [PEEK_IDX_W-1:0] cnt_ff, cnt_in, drain_ff, drain_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  banner_ff, banner_in;
   logic [2:0]            hidx_ff, hidx_in, pidx_ff, pidx_in;
   logic [31:0]           hlen_ff, hlen_in, left_ff, left_in, plen_ff, plen_in;
   logic [31:0]           fp_ff, fp_in, cur_ff, cur_in, prev_ff, prev_in;
   logic                  seen_ff, seen_in;

   logic [1:0]  fin_mode;
   logic [31:0] h0, h7, raw_peek_len, raw_word_len, start_len, ew;
   logic [31:0] eff_len, eff_left, eff_fp, eff_cur;
   logic [2:0]  eff_pidx;
   logic        emit_eor, lm, ooo;

   logic        valid_ff;
   logic [31:0] word_ff, frame_ff;
   logic [2:0]  status_ff;
   logic        eor_ff, eorun_ff, lm_ff, ooo_ff, banner_out_ff;
   logic [1:0]  found_ff;

   // detection checks over the peek store
   always_comb begin
      fin_mode = framing_mode_ff;
      if (framing_mode_ff == MODE_AUTO) begin
         if (peek_ff[9] == REC_MAGIC)      fin_mode = MODE_PREFIXED;
         else if (peek_ff[7] == REC_MAGIC) fin_mode = MODE_HEADER;
         else                              fin_mode = MODE_AUTO;
      end
   end

   assign h0           = (fin_mode == MODE_PREFIXED) ? peek_ff[2] : peek_ff[0];
   assign h7           = (fin_mode == MODE_PREFIXED) ? peek_ff[9] : peek_ff[7];
   assign raw_peek_len = peek_ff[0] + 32'd1;
   assign raw_word_len = req_word + 32'd1;

   always_comb begin
      stat             = '0;
      stat.out_free    = !valid_ff || rsp_ready;
      stat.peek_cnt    = cnt_ff;
      stat.banner      = banner_ff;
      stat.hidx        = hidx_ff;
      stat.mode        = mode_ff;
      stat.fin_banner  = !banner_ff && peek_ff[0] == REC_MAGIC && peek_ff[1] != REC_MAGIC;
      stat.fin_mode    = fin_mode;
      stat.fin_swapped = peek_ff[7] == REC_MAGIC_SWAPPED || peek_ff[9] == REC_MAGIC_SWAPPED;
      stat.fin_hdr_ok  = h7 == REC_MAGIC;
      if (fin_mode == MODE_RAW) begin
         stat.fin_len_ok = raw_peek_len >= PEEK_WORDS && raw_peek_len <= max_words_ff;
      end else begin
         stat.fin_len_ok = h0 > HDR_WORDS && h0 <= max_words_ff;
      end
      stat.word_magic = req_word == REC_MAGIC;
      stat.hlen_ok    = hlen_ff > HDR_WORDS && hlen_ff <= max_words_ff;
      stat.raw_ok     = raw_word_len >= 32'd2 && raw_word_len <= max_words_ff;
      stat.last_word  = left_ff == 32'd1;
      stat.drain_idx  = drain_ff;
   end

   // record start and payload bookkeeping
   always_comb begin
      case (cmd.start_src)
         START_HDR:  start_len = hlen_ff - HDR_WORDS;
         START_PEEK: start_len = (fin_mode == MODE_RAW) ? raw_peek_len : h0 - HDR_WORDS;
         START_RAW:  start_len = raw_word_len;
         default:    start_len = plen_ff;
      endcase
   end

   always_comb begin
      if (cmd.start_src != START_NONE) begin
         eff_len  = start_len;
         eff_left = start_len;
         eff_pidx = '0;
         eff_fp   = '0;
         eff_cur  = '0;
      end else begin
         eff_len  = plen_ff;
         eff_left = left_ff;
         eff_pidx = pidx_ff;
         eff_fp   = fp_ff;
         eff_cur  = cur_ff;
      end
   end

   assign ew = cmd.emit_peek ? peek_ff[drain_ff] : req_word;

   always_comb begin
      cnt_in    = cnt_ff;
      drain_in  = drain_ff;
      mode_in   = mode_ff;
      banner_in = banner_ff;
      hidx_in   = hidx_ff;
      hlen_in   = hlen_ff;
      left_in   = eff_left;
      plen_in   = eff_len;
      pidx_in   = eff_pidx;
      fp_in     = eff_fp;
      cur_in    = eff_cur;
      prev_in   = prev_ff;
      seen_in   = seen_ff;
      emit_eor  = 1'b0;
      lm        = 1'b0;
      ooo       = 1'b0;

      if (cmd.peek_wr)      cnt_in = cnt_ff + PEEK_IDX_W'(1);
      if (cmd.banner_shift) begin
         cnt_in    = PEEK_IDX_W'(8);
         banner_in = 1'b1;
      end
      if (cmd.hidx_inc) hidx_in = hidx_ff + 3'd1;
      if (cmd.hidx_clr) hidx_in = '0;
      if (cmd.hlen_ld)  hlen_in = req_word;
      if (cmd.mode_ld)  mode_in = fin_mode;
      if (cmd.drain_ld) drain_in = cmd.drain_start;
      if (cmd.drain_inc) drain_in = drain_ff + PEEK_IDX_W'(1);

      if (cmd.emit) begin
         if (eff_pidx == 3'd0) fp_in = ew;
         if (eff_pidx == 3'd5) cur_in = ew;
         if (eff_pidx < 3'd6)  pidx_in = eff_pidx + 3'd1;
         left_in  = eff_left - 32'd1;
         emit_eor = eff_left == 32'd1;
         if (emit_eor) begin
            lm      = eff_len >= 32'd1 && fp_in != eff_len - 32'd1;
            ooo     = seen_ff && cur_in <= prev_ff;
            seen_in = 1'b1;
            prev_in = cur_in;
         end
      end

      // connection end: back to a fresh connection, frame history flag kept
      if (cmd.close) begin
         cnt_in    = '0;
         mode_in   = MODE_AUTO;
         banner_in = 1'b0;
         hidx_in   = '0;
         hlen_in   = '0;
         left_in   = '0;
         plen_in   = '0;
         pidx_in   = '0;
         fp_in     = '0;
         cur_in    = '0;
         prev_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.peek_wr) begin
         peek_ff[cnt_ff] <= req_word;
      end else if (cmd.banner_shift) begin
         for (int i = 0; i < PEEK_DEPTH - 2; i++) peek_ff[i] <= peek_ff[i + 2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         framing_mode_ff <= MODE_AUTO;
         max_words_ff    <= MAX_WORDS_RESET;
         cnt_ff          <= '0;
         drain_ff        <= '0;
         mode_ff         <= MODE_AUTO;
         banner_ff       <= 1'b0;
         hidx_ff         <= '0;
         hlen_ff         <= '0;
         left_ff         <= '0;
         plen_ff         <= '0;
         pidx_ff         <= '0;
         fp_ff           <= '0;
         cur_ff          <= '0;
         prev_ff         <= '0;
         seen_ff         <= 1'b0;
         valid_ff        <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_FRAMING_MODE) framing_mode_ff <= csr_wdata[1:0];
         if (csr_we && csr_index == CSR_MAX_WORDS)    max_words_ff    <= csr_wdata;
         cnt_ff    <= cnt_in;
         drain_ff  <= drain_in;
         mode_ff   <= mode_in;
         banner_ff <= banner_in;
         hidx_ff   <= hidx_in;
         hlen_ff   <= hlen_in;
         left_ff   <= left_in;
         plen_ff   <= plen_in;
         pidx_ff   <= pidx_in;
         fp_ff     <= fp_in;
         cur_ff    <= cur_in;
         prev_ff   <= prev_in;
         seen_ff   <= seen_in;
         if (cmd.put)      valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         word_ff       <= cmd.emit ? ew : '0;
         status_ff     <= cmd.emit ? STAT_PAYLOAD : cmd.put_status;
         eor_ff        <= emit_eor;
         eorun_ff      <= cmd.end_run;
         lm_ff         <= lm;
         ooo_ff        <= ooo;
         frame_ff      <= emit_eor ? cur_in : '0;
         found_ff      <= cmd.mode_ld ? fin_mode : mode_ff;
         banner_out_ff <= banner_ff;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_payload_word    = word_ff;
   assign rsp_status          = status_ff;
   assign rsp_end_of_record   = eor_ff;
   assign rsp_end_of_run      = eorun_ff;
   assign rsp_length_mismatch = lm_ff;
   assign rsp_order_fault     = ooo_ff;
   assign rsp_frame_tag       = frame_ff;
   assign rsp_framing_found   = found_ff;
   assign rsp_banner_seen     = banner_out_ff;

endmodule
`default_nettype wire
